>>> rtl/rom_pin_net_resolver_top_assert.svh
// assertion macros for the rom pin net resolver
`ifndef ROM_PIN_NET_RESOLVER_TOP_ASSERT_SVH
`define ROM_PIN_NET_RESOLVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RPNR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpnr check failed");
`define RPNR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpnr check failed");
`else
`define RPNR_ASSERT_SAME(lbl, ante, cons)
`define RPNR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/rpnr_pkg.sv
// shared types, constants and pin tables of the rom pin net resolver
package rpnr_pkg;

  localparam int PINS      = 28;
  localparam int PIN_IDX_W = $clog2(PINS);
  localparam int ROM_PINS  = 28;
  localparam int ROM_PIN_W = 5;
  localparam int LEVELS_W  = 2 * ROM_PINS;
  localparam int PIN_W     = 5;
  localparam int OP_W      = 2;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int POLICY_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = LEVELS_W;
  localparam int SRC_W     = 6;

  localparam logic [PIN_IDX_W-1:0] LAST_ROW = PIN_IDX_W'(PINS - 1);

  localparam logic [OP_W-1:0] OP_LINK   = 2'd0;
  localparam logic [OP_W-1:0] OP_BEND   = 2'd1;
  localparam logic [OP_W-1:0] OP_DRIVES = 2'd2;

  localparam logic [1:0] LV_LOW   = 2'd0;
  localparam logic [1:0] LV_HIGH  = 2'd1;
  localparam logic [1:0] LV_FLOAT = 2'd2;

  localparam logic [POLICY_W-1:0] POL_HIGH_WINS = 2'd0;
  localparam logic [POLICY_W-1:0] POL_LOW_WINS  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_RESET     = 2'd2;

  localparam logic [LEVELS_W-1:0] ALL_FLOAT = 56'hAAAAAAAAAAAAAA;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVES = 1'b1;

  // source codes: address bit, data bit plus 16, fixed low, fixed high
  localparam logic [SRC_W-1:0] SRC_DATA0 = 6'd16;
  localparam logic [SRC_W-1:0] SRC_LOW   = 6'd32;
  localparam logic [SRC_W-1:0] SRC_HIGH  = 6'd33;
  localparam logic [SRC_W-1:0] SRC_NONE  = 6'd34;

  localparam logic [ROM_PIN_W-1:0] DATA_PIN [DATA_W] =
    '{5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK,
    ST_INIT,
    ST_SWEEP,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic                 link_we;
    logic                 load;
    logic                 step;
    logic                 finish;
    logic [PIN_IDX_W-1:0] row;
  } seq_ctrl_t;

  function automatic logic [SRC_W-1:0] pin_source(input logic [ROM_PIN_W-1:0] p);
    logic [SRC_W-1:0] s;
    case (p)
      5'd0:    s = 6'd14;
      5'd1:    s = 6'd12;
      5'd2:    s = 6'd7;
      5'd3:    s = 6'd6;
      5'd4:    s = 6'd5;
      5'd5:    s = 6'd4;
      5'd6:    s = 6'd3;
      5'd7:    s = 6'd2;
      5'd8:    s = 6'd1;
      5'd9:    s = 6'd0;
      5'd10:   s = 6'd16;
      5'd11:   s = 6'd17;
      5'd12:   s = 6'd18;
      5'd13:   s = SRC_LOW;
      5'd14:   s = 6'd19;
      5'd15:   s = 6'd20;
      5'd16:   s = 6'd21;
      5'd17:   s = 6'd22;
      5'd18:   s = 6'd23;
      5'd19:   s = SRC_LOW;
      5'd20:   s = 6'd10;
      5'd21:   s = SRC_LOW;
      5'd22:   s = 6'd11;
      5'd23:   s = 6'd9;
      5'd24:   s = 6'd8;
      5'd25:   s = 6'd13;
      5'd26:   s = 6'd15;
      5'd27:   s = SRC_HIGH;
      default: s = SRC_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] mix_level(input logic hi, input logic lo,
                                           input logic [POLICY_W-1:0] policy);
    logic [1:0] r;
    if (hi && lo) begin
      if (policy == POL_HIGH_WINS) begin
        r = LV_HIGH;
      end else if (policy == POL_LOW_WINS) begin
        r = LV_LOW;
      end else begin
        r = LV_FLOAT;
      end
    end else if (hi) begin
      r = LV_HIGH;
    end else if (lo) begin
      r = LV_LOW;
    end else begin
      r = LV_FLOAT;
    end
    return r;
  endfunction

endpackage

>>> rtl/rpnr_link_matrix.sv
// symmetric pin link matrix with one row read port
module rpnr_link_matrix
  import rpnr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  seq_ctrl_t            ctrl,
  input  logic [PIN_IDX_W-1:0] pin_a,
  input  logic [PIN_IDX_W-1:0] pin_b,
  input  logic                 connected,
  output logic [PINS-1:0]      row_bits
);

  logic [PINS-1:0] rows [PINS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PINS; i++) begin
        rows[i] <= '0;
      end
    end else if (ctrl.link_we) begin
      rows[pin_a][pin_b] <= connected;
      rows[pin_b][pin_a] <= connected;
    end
  end

  assign row_bits = rows[ctrl.row];

endmodule

>>> rtl/rpnr_prop_unit.sv
// shared net propagation unit: merges one matrix row into the level flags per cycle while the sequencer steps
module rpnr_prop_unit
  import rpnr_pkg::*;
(
  input  logic            clk,
  input  seq_ctrl_t       ctrl,
  input  logic [PINS-1:0] lv_hi,
  input  logic [PINS-1:0] lv_lo,
  input  logic [PINS-1:0] row_bits,
  output logic [PINS-1:0] net_hi,
  output logic [PINS-1:0] net_lo,
  output logic            row_changed
);

  logic hit_hi;
  logic hit_lo;

  assign hit_hi      = |(row_bits & net_hi);
  assign hit_lo      = |(row_bits & net_lo);
  assign row_changed = (hit_hi && !net_hi[ctrl.row]) || (hit_lo && !net_lo[ctrl.row]);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      net_hi <= lv_hi;
      net_lo <= lv_lo;
    end else if (ctrl.step) begin
      net_hi[ctrl.row] <= net_hi[ctrl.row] | hit_hi;
      net_lo[ctrl.row] <= net_lo[ctrl.row] | hit_lo;
    end
  end

endmodule

>>> rtl/rpnr_seq.sv
// sequencer: link write, row sweeps until a sweep changes nothing, result
module rpnr_seq
  import rpnr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start_beat,
  input  logic [OP_W-1:0] op,
  input  logic            pair_ok,
  input  logic            row_changed,
  output seq_ctrl_t       ctrl,
  output logic            busy
);

  seq_state_t           state;
  seq_state_t           state_next;
  logic [PIN_IDX_W-1:0] row;
  logic [PIN_IDX_W-1:0] row_next;
  logic                 sweep_chg;
  logic                 sweep_chg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      sweep_chg <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      sweep_chg <= sweep_chg_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_beat) begin
          case (op)
            OP_LINK:   state_next = ST_LINK;
            OP_BEND:   state_next = ST_INIT;
            OP_DRIVES: state_next = ST_INIT;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_LINK:  state_next = ST_DONE;
      ST_INIT:  state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (row == LAST_ROW && !sweep_chg && !row_changed) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    row_next       = row;
    sweep_chg_next = sweep_chg;
    ctrl.link_we   = 1'b0;
    ctrl.load      = 1'b0;
    ctrl.step      = 1'b0;
    ctrl.finish    = 1'b0;
    ctrl.row       = row;
    busy           = 1'b1;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_LINK: ctrl.link_we = pair_ok;
      ST_INIT: begin
        ctrl.load      = 1'b1;
        row_next       = '0;
        sweep_chg_next = 1'b0;
      end
      ST_SWEEP: begin
        ctrl.step = 1'b1;
        if (row == LAST_ROW) begin
          row_next       = '0;
          sweep_chg_next = 1'b0;
        end else begin
          row_next       = row + 1'b1;
          sweep_chg_next = sweep_chg | row_changed;
        end
      end
      ST_DONE: ctrl.finish = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

>>> rtl/rom_pin_net_resolver_top.sv
// rom pin net resolver: link matrix, drive levels, net resolution and data bending
// done is registered from the done state; a link op reaches it through the link write
// state, an unused op straight from idle; reads and hint resolves pass an init state and
// S row sweeps of the shared propagation unit (1 to 28, until a sweep over all 28 rows
// changes nothing); a new item waits for idle, busy drops as done rises; done strobe, no stall
// synchronous reset resets links, policy and done; drive hints and resolved levels go all floating
`include "rom_pin_net_resolver_top_assert.svh"
module rom_pin_net_resolver_top
  import rpnr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      op,
  input  logic [PIN_W-1:0]     pin_a,
  input  logic [PIN_W-1:0]     pin_b,
  input  logic                 connected,
  input  logic [ADDR_W-1:0]    address,
  input  logic [DATA_W-1:0]    data,
  output logic                 done,
  output logic                 accepted,
  output logic [DATA_W-1:0]    bent_byte,
  output logic [LEVELS_W-1:0]  pin_levels,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [OP_W-1:0]     op_r;
  logic [PIN_W-1:0]    pin_a_r;
  logic [PIN_W-1:0]    pin_b_r;
  logic                conn_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   data_r;
  logic [POLICY_W-1:0] policy;
  logic [LEVELS_W-1:0] pin_drives;
  logic [LEVELS_W-1:0] resolved;
  logic                start_beat;
  logic                pair_ok;
  logic                row_changed;
  logic [PINS-1:0]     row_bits;
  logic [PINS-1:0]     lv_hi;
  logic [PINS-1:0]     lv_lo;
  logic [PINS-1:0]     net_hi;
  logic [PINS-1:0]     net_lo;
  logic [LEVELS_W-1:0] new_levels;
  logic [DATA_W-1:0]   bent_new;
  seq_ctrl_t           ctrl;

  assign start_beat = start && !busy;
  assign cfg_ready  = 1'b1;
  assign pair_ok    = ({1'b0, pin_a_r} < (PIN_W + 1)'(PINS)) &&
                      ({1'b0, pin_b_r} < (PIN_W + 1)'(PINS)) && (pin_a_r != pin_b_r);

  always_ff @(posedge clk) begin
    if (start_beat) begin
      op_r    <= op;
      pin_a_r <= pin_a;
      pin_b_r <= pin_b;
      conn_r  <= connected;
      addr_r  <= address;
      data_r  <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POL_RESET;
      pin_drives <= ALL_FLOAT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLICY: policy     <= cfg_data[POLICY_W-1:0];
        CFG_DRIVES: pin_drives <= cfg_data;
        default:    policy     <= policy;
      endcase
    end
  end

  // per pin drive from the read beat and the drive hints
  always_comb begin
    logic [SRC_W-1:0] src;
    logic [1:0]       drv;
    logic             b;
    lv_hi = '0;
    lv_lo = '0;
    for (int i = 0; i < ROM_PINS; i++) begin
      src = pin_source(ROM_PIN_W'(i));
      drv = pin_drives[2*i +: 2];
      b   = 1'b0;
      if (drv == LV_LOW) begin
        lv_lo[i] = 1'b1;
      end else if (drv == LV_HIGH) begin
        lv_hi[i] = 1'b1;
      end else if (op_r == OP_BEND) begin
        if (src < SRC_DATA0) begin
          b        = addr_r[src[3:0]];
          lv_hi[i] = b;
          lv_lo[i] = !b;
        end else if (src < SRC_LOW) begin
          b        = data_r[src[2:0]];
          lv_hi[i] = b;
          lv_lo[i] = !b;
        end else if (src == SRC_LOW) begin
          lv_lo[i] = 1'b1;
        end else if (src == SRC_HIGH) begin
          lv_hi[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [1:0] r;
    new_levels = '0;
    for (int i = 0; i < ROM_PINS; i++) begin
      new_levels[2*i +: 2] = mix_level(net_hi[i], net_lo[i], policy);
    end
    bent_new = data_r;
    for (int k = 0; k < DATA_W; k++) begin
      r = new_levels[2*int'(DATA_PIN[k]) +: 2];
      if (r == LV_HIGH) begin
        bent_new[k] = 1'b1;
      end else if (r == LV_LOW) begin
        bent_new[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      resolved <= ALL_FLOAT;
    end else begin
      done <= ctrl.finish;
      if (ctrl.finish && (op_r == OP_BEND || op_r == OP_DRIVES)) begin
        resolved <= new_levels;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      case (op_r)
        OP_LINK: begin
          accepted   <= pair_ok;
          bent_byte  <= data_r;
          pin_levels <= resolved;
        end
        OP_BEND: begin
          accepted   <= 1'b1;
          bent_byte  <= bent_new;
          pin_levels <= new_levels;
        end
        OP_DRIVES: begin
          accepted   <= 1'b1;
          bent_byte  <= data_r;
          pin_levels <= new_levels;
        end
        default: begin
          accepted   <= 1'b0;
          bent_byte  <= data_r;
          pin_levels <= resolved;
        end
      endcase
    end
  end

  rpnr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start_beat  (start_beat),
    .op          (op),
    .pair_ok     (pair_ok),
    .row_changed (row_changed),
    .ctrl        (ctrl),
    .busy        (busy)
  );

  rpnr_link_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .pin_a     (pin_a_r[PIN_IDX_W-1:0]),
    .pin_b     (pin_b_r[PIN_IDX_W-1:0]),
    .connected (conn_r),
    .row_bits  (row_bits)
  );

  rpnr_prop_unit u_prop (
    .clk         (clk),
    .ctrl        (ctrl),
    .lv_hi       (lv_hi),
    .lv_lo       (lv_lo),
    .row_bits    (row_bits),
    .net_hi      (net_hi),
    .net_lo      (net_lo),
    .row_changed (row_changed)
  );

  `RPNR_ASSERT_NEXT(a_accept_busy, start_beat, busy)
  `RPNR_ASSERT_SAME(a_done_idle, done, !busy)
  `RPNR_ASSERT_NEXT(a_done_single, done, !done)

endmodule

>>> test/testbench.sv
// self-checking testbench for the rom pin net resolver: directed and random traffic
module testbench;
  import rpnr_pkg::*;

  localparam logic [OP_W-1:0]     OP_UNUSED  = 2'd3;
  localparam logic [POLICY_W-1:0] POL_SPARE  = 2'd3;
  localparam logic [CFG_W-1:0]    ALL_LOW    = '0;
  localparam logic [CFG_W-1:0]    ALL_HIGH   = 56'h55555555555555;
  localparam logic [CFG_W-1:0]    NO_DRIVE   = 56'hFFFFFFFFFFFFFF;
  localparam int                  GND_PIN    = 13;
  localparam int                  CE_PIN     = 19;
  localparam int                  OE_PIN     = 21;
  localparam int                  VCC_PIN    = 27;
  localparam int                  ITEM_GOAL  = 1050;
  localparam int                  CYCLE_CAP  = 4000000;
  localparam int PIN_ADDR_BIT [ROM_PINS] = '{14, 12, 7, 6, 5, 4, 3, 2, 1, 0,
                                            -1, -1, -1, -1, -1, -1, -1, -1, -1, -1,
                                            10, -1, 11, 9, 8, 13, 15, -1};

  typedef enum logic [1:0] {
    MIX_LINKS,
    PRUNE_LINKS,
    BUILD_CHAIN
  } phase_kind_t;

  typedef struct packed {
    logic                acc;
    logic [DATA_W-1:0]   bent;
    logic [LEVELS_W-1:0] levels;
  } outcome_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      op;
  logic [PIN_W-1:0]     pin_a;
  logic [PIN_W-1:0]     pin_b;
  logic                 connected;
  logic [ADDR_W-1:0]    address;
  logic [DATA_W-1:0]    data;
  logic                 done;
  logic                 accepted;
  logic [DATA_W-1:0]    bent_byte;
  logic [LEVELS_W-1:0]  pin_levels;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predictor state
  logic [ROM_PINS-1:0]  link_rows [ROM_PINS];
  logic [LEVELS_W-1:0]  net_levels;
  logic [POLICY_W-1:0]  policy_now;
  logic [CFG_W-1:0]     drive_hints;

  outcome_t             pending_results [$];
  int                   fail_count;
  int                   items_sent;
  int                   cycle_count;
  bit                   calm;

  rom_pin_net_resolver_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .pin_a      (pin_a),
    .pin_b      (pin_b),
    .connected  (connected),
    .address    (address),
    .data       (data),
    .done       (done),
    .accepted   (accepted),
    .bent_byte  (bent_byte),
    .pin_levels (pin_levels),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic outcome_t resolve_item(input logic [OP_W-1:0] o,
                                            input logic [PIN_W-1:0] a,
                                            input logic [PIN_W-1:0] b,
                                            input logic c,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [DATA_W-1:0] d);
    outcome_t            r;
    logic [1:0]          drv [ROM_PINS];
    logic [1:0]          lvl;
    logic [ROM_PINS-1:0] reach;
    logic [ROM_PINS-1:0] seen;
    logic                hi;
    logic                lo;
    r.acc = 1'b0;
    r.bent = d;
    r.levels = net_levels;
    if (o == OP_LINK) begin
      if (a < ROM_PINS && b < ROM_PINS && a != b) begin
        link_rows[a][b] = c;
        link_rows[b][a] = c;
        r.acc = 1'b1;
      end
    end else if (o == OP_BEND || o == OP_DRIVES) begin
      for (int p = 0; p < ROM_PINS; p++) drv[p] = LV_FLOAT;
      if (o == OP_BEND) begin
        for (int p = 0; p < ROM_PINS; p++) begin
          if (PIN_ADDR_BIT[p] >= 0) drv[p] = {1'b0, addr[PIN_ADDR_BIT[p]]};
        end
        for (int k = 0; k < DATA_W; k++) drv[DATA_PIN[k]] = {1'b0, d[k]};
        drv[GND_PIN] = LV_LOW;
        drv[CE_PIN]  = LV_LOW;
        drv[OE_PIN]  = LV_LOW;
        drv[VCC_PIN] = LV_HIGH;
      end
      // hints 0 and 1 override, 2 and 3 leave the pin alone
      for (int p = 0; p < ROM_PINS; p++) begin
        if (!drive_hints[2*p+1]) drv[p] = {1'b0, drive_hints[2*p]};
      end
      for (int p = 0; p < ROM_PINS; p++) begin
        reach = '0;
        reach[p] = 1'b1;
        seen = '0;
        while (seen != reach) begin
          seen = reach;
          for (int q = 0; q < ROM_PINS; q++) begin
            if (seen[q]) reach = reach | link_rows[q];
          end
        end
        hi = 1'b0;
        lo = 1'b0;
        for (int q = 0; q < ROM_PINS; q++) begin
          if (reach[q] && drv[q] == LV_HIGH) hi = 1'b1;
          if (reach[q] && drv[q] == LV_LOW) lo = 1'b1;
        end
        if (hi && lo) begin
          if (policy_now == POL_HIGH_WINS) lvl = LV_HIGH;
          else if (policy_now == POL_LOW_WINS) lvl = LV_LOW;
          else lvl = LV_FLOAT;
        end else if (hi) begin
          lvl = LV_HIGH;
        end else if (lo) begin
          lvl = LV_LOW;
        end else begin
          lvl = LV_FLOAT;
        end
        net_levels[2*p +: 2] = lvl;
      end
      if (o == OP_BEND) begin
        for (int k = 0; k < DATA_W; k++) begin
          lvl = net_levels[2*DATA_PIN[k] +: 2];
          if (lvl != LV_FLOAT) r.bent[k] = lvl[0];
        end
      end
      r.acc = 1'b1;
      r.levels = net_levels;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic [PIN_W-1:0] pick_pin();
    if ($urandom_range(0, 99) < 88) return PIN_W'($urandom_range(0, ROM_PINS - 1));
    return PIN_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [CFG_W-1:0] random_hints();
    logic [CFG_W-1:0] h;
    h = CFG_W'({$urandom, $urandom});
    if ($urandom_range(0, 9) >= 3) begin
      for (int p = 0; p < ROM_PINS; p++) begin
        if ($urandom_range(0, 99) < 12) h[2*p +: 2] = 2'($urandom_range(0, 1));
        else h[2*p +: 2] = 2'($urandom_range(2, 3));
      end
    end
    return h;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] o, input logic [PIN_W-1:0] a,
                           input logic [PIN_W-1:0] b, input logic c,
                           input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] d);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    op        <= o;
    pin_a     <= a;
    pin_b     <= b;
    connected <= c;
    address   <= addr;
    data      <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(resolve_item(o, a, b, c, addr, d));
    items_sent++;
  endtask

  task automatic send_link(input logic [PIN_W-1:0] a, input logic [PIN_W-1:0] b,
                           input logic c);
    send_item(OP_LINK, a, b, c, ADDR_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic send_read(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] d);
    send_item(o, PIN_W'($urandom), PIN_W'($urandom), 1'($urandom), addr, d);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_POLICY) policy_now = value[POLICY_W-1:0];
    else drive_hints = value;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_read(OP_DRIVES, 16'h0000, 8'h00);
    send_item(OP_UNUSED, 5'd31, 5'd0, 1'b1, 16'hFFFF, 8'hFF);
    send_read(OP_BEND, 16'hFFFF, 8'h00);
  endtask

  task automatic test_link_checks();
    send_link(5'd28, 5'd0, 1'b1);
    send_link(5'd3, 5'd31, 1'b1);
    send_link(5'd5, 5'd5, 1'b1);
    send_link(5'd31, 5'd31, 1'b0);
    send_link(5'd0, PIN_W'(VCC_PIN), 1'b1);
    send_link(5'd10, PIN_W'(GND_PIN), 1'b1);
    send_link(5'd18, PIN_W'(VCC_PIN), 1'b1);
  endtask

  task automatic test_bend_extremes();
    send_read(OP_BEND, 16'h0000, 8'hFF);
    send_read(OP_BEND, 16'hFFFF, 8'h00);
    send_read(OP_BEND, 16'hA5A5, 8'h5A);
    send_read(OP_DRIVES, 16'h1234, 8'hC3);
  endtask

  task automatic test_policy_and_hints();
    logic [POLICY_W-1:0] pols [4];
    pols = '{POL_HIGH_WINS, POL_LOW_WINS, POL_RESET, POL_SPARE};
    foreach (pols[i]) begin
      settle();
      write_reg(CFG_POLICY, CFG_W'(pols[i]));
      send_read(OP_BEND, 16'h0000, 8'hFF);
    end
    settle();
    write_reg(CFG_DRIVES, ALL_LOW);
    send_read(OP_DRIVES, 16'hFFFF, 8'hFF);
    settle();
    write_reg(CFG_DRIVES, ALL_HIGH);
    send_read(OP_BEND, 16'hFFFF, 8'h00);
    settle();
    write_reg(CFG_DRIVES, NO_DRIVE);
    send_read(OP_BEND, ADDR_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic test_random_traffic();
    int               phase;
    int               phase_end;
    int               pconn;
    int               chain_pin;
    bit               found;
    phase_kind_t      kind;
    logic [CFG_W-1:0] pol_word;
    logic [PIN_W-1:0] a;
    logic [PIN_W-1:0] b;
    phase = 0;
    chain_pin = VCC_PIN;
    while (items_sent < ITEM_GOAL) begin
      settle();
      pol_word = CFG_W'({$urandom, $urandom});
      pol_word[POLICY_W-1:0] = (phase < 4) ? POLICY_W'(phase) : POLICY_W'($urandom_range(0, 3));
      write_reg(CFG_POLICY, pol_word);
      write_reg(CFG_DRIVES, (phase == 0) ? ALL_FLOAT : random_hints());
      calm = (phase % 3 == 2);
      case (phase % 5)
        3:       kind = PRUNE_LINKS;
        4:       kind = BUILD_CHAIN;
        default: kind = MIX_LINKS;
      endcase
      pconn = $urandom_range(30, 70);
      phase_end = items_sent + 85;
      while (items_sent < phase_end && items_sent < ITEM_GOAL) begin
        repeat ($urandom_range(0, 4)) begin
          case (kind)
            BUILD_CHAIN: begin
              send_link(PIN_W'(chain_pin), PIN_W'(chain_pin - 1), 1'b1);
              chain_pin = (chain_pin > 1) ? chain_pin - 1 : VCC_PIN;
            end
            PRUNE_LINKS: begin
              found = 1'b0;
              a = '0;
              b = '0;
              for (int t = 0; t < 40 && !found; t++) begin
                a = PIN_W'($urandom_range(0, ROM_PINS - 1));
                b = PIN_W'($urandom_range(0, ROM_PINS - 1));
                found = link_rows[a][b];
              end
              send_link(a, b, 1'b0);
            end
            default: begin
              send_link(pick_pin(), pick_pin(), 1'($urandom_range(0, 99) < pconn));
            end
          endcase
        end
        repeat ($urandom_range(1, 3)) begin
          send_read(($urandom_range(0, 99) < 78) ? OP_BEND : OP_DRIVES,
                    ADDR_W'($urandom), DATA_W'($urandom));
        end
        // occasional noise: unused op or a pin pair off the package
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            send_item(OP_UNUSED, PIN_W'($urandom), PIN_W'($urandom), 1'($urandom),
                      ADDR_W'($urandom), DATA_W'($urandom));
          end else begin
            send_link(PIN_W'($urandom_range(ROM_PINS, 31)), pick_pin(), 1'($urandom));
          end
        end
      end
      phase++;
    end
  endtask

  always @(posedge clk) begin : check_beat
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected: accepted %0d bent_byte %h pin_levels %h",
                 $time, accepted, bent_byte, pin_levels);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (accepted !== want.acc) begin
          $display("%0t: accepted expected %0d actual %0d", $time, want.acc, accepted);
          fail_count++;
        end
        if (bent_byte !== want.bent) begin
          $display("%0t: bent_byte expected %h actual %h", $time, want.bent, bent_byte);
          fail_count++;
        end
        if (pin_levels !== want.levels) begin
          $display("%0t: pin_levels expected %h actual %h", $time, want.levels, pin_levels);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    op        <= OP_LINK;
    pin_a     <= '0;
    pin_b     <= '0;
    connected <= 1'b0;
    address   <= '0;
    data      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_POLICY;
    cfg_data  <= '0;
    for (int p = 0; p < ROM_PINS; p++) link_rows[p] = '0;
    net_levels  = ALL_FLOAT;
    policy_now  = POL_RESET;
    drive_hints = ALL_FLOAT;
    fail_count  = 0;
    items_sent  = 0;
    cycle_count = 0;
    calm        = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_link_checks();
    test_bend_extremes();
    test_policy_and_hints();
    test_random_traffic();
    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
